// File: design/jet_pkg.sv
package jet_pkg;

  localparam int FRAC_BITS  = 28;
  localparam int COUNT_BITS = 16;
  localparam int NUM_CELLS  = 4;

  localparam int DATA_W  = 32;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int MAG_W   = 34;
  localparam int LIMIT_W = 16;
  localparam int OCNT_W  = 16;

  localparam int IN_TDATA_W  = 2 * DATA_W;
  localparam int OUT_FIELD_W = OCNT_W + 1 + MAG_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DATA_W;

  // Escape is |z|^2 >= 4, that is 2^(2*FRAC_BITS+2) in the product format.
  localparam int ESC_SHIFT   = 2 * FRAC_BITS + 2;
  localparam bit ESC_ON      = (ESC_SHIFT < PROD_W);
  localparam int ESC_SHIFT_C = ESC_ON ? ESC_SHIFT : PROD_W - 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [LIMIT_W-1:0]    LIMIT_RESET = LIMIT_W'(256);
  localparam logic [MAG_W-1:0]      MAG_MAX = '1;

  localparam logic signed [PROD_W:0] SAT_HI = (PROD_W + 1)'(2 ** (DATA_W - 1) - 1);
  localparam logic signed [PROD_W:0] SAT_LO = -SAT_HI - (PROD_W + 1)'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONST_REAL = 2'd0,
    CFG_CONST_IMAG = 2'd1,
    CFG_ITER_LIMIT = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] const_real;
    logic signed [DATA_W-1:0] const_imag;
    logic [COUNT_BITS-1:0]    limit_eff;
  } jet_cfg_t;

  // One pixel as it travels along the ring of cells.
  typedef struct packed {
    logic                     valid;
    logic                     done;
    logic                     reached;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic [COUNT_BITS-1:0]    count;
    logic [MAG_W-1:0]         mag;
  } cell_data_t;

  function automatic logic signed [DATA_W-1:0] sat_part(input logic signed [PROD_W:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[DATA_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: design/jet_cell.sv
module jet_cell (
  input  logic                clk,
  input  logic                rst,
  input  jet_pkg::jet_cfg_t   cfg,
  input  jet_pkg::cell_data_t din,
  output jet_pkg::cell_data_t dout
);
  import jet_pkg::*;

  cell_data_t               mid;
  cell_data_t               dout_next;
  logic signed [PROD_W-1:0] xx;
  logic signed [PROD_W-1:0] yy;
  logic signed [PROD_W-1:0] xy;

  logic [PROD_W-1:0]        mag;
  logic [PROD_W-1:0]        mag_sh;
  logic                     esc;
  logic [MAG_W-1:0]         mag_sat;
  logic signed [PROD_W-1:0] diff;
  logic signed [PROD_W-1:0] re_sh;
  logic signed [PROD_W-1:0] im_sh;
  logic signed [PROD_W:0]   re_sum;
  logic signed [PROD_W:0]   im_sum;

  // First stage: the three products of the current z.
  always_ff @(posedge clk) begin
    if (rst) begin
      mid <= '0;
    end else begin
      mid <= din;
    end
    xx <= din.x * din.x;
    yy <= din.y * din.y;
    xy <= din.x * din.y;
  end

  always_comb begin
    mag     = $unsigned(xx) + $unsigned(yy);
    esc     = ESC_ON && ((mag >> ESC_SHIFT_C) != '0);
    mag_sh  = mag >> FRAC_BITS;
    mag_sat = ((mag_sh >> MAG_W) != '0) ? MAG_MAX : mag_sh[MAG_W-1:0];
    diff    = xx - yy;
    re_sh   = diff >>> FRAC_BITS;
    im_sh   = xy >>> (FRAC_BITS - 1);
    re_sum  = {re_sh[PROD_W-1], re_sh}
            + {{(PROD_W + 1 - DATA_W){cfg.const_real[DATA_W-1]}}, cfg.const_real};
    im_sum  = {im_sh[PROD_W-1], im_sh}
            + {{(PROD_W + 1 - DATA_W){cfg.const_imag[DATA_W-1]}}, cfg.const_imag};
  end

  // Second stage: escape and limit test, then either finish the pixel or take one step.
  always_comb begin
    dout_next = mid;
    if (mid.valid && !mid.done) begin
      if (esc || (mid.count >= cfg.limit_eff)) begin
        dout_next.done    = 1'b1;
        dout_next.reached = !esc;
        dout_next.mag     = mag_sat;
      end else begin
        dout_next.x     = sat_part(re_sum);
        dout_next.y     = sat_part(im_sum);
        dout_next.count = mid.count + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else begin
      dout <= dout_next;
    end
  end

endmodule

// File: design/julia_escape_time.sv
// An accepted pixel steps through the ring of cells, each of which registers it in mid
// and then in dout, and a finished pixel enters the output register from the last cell.
// The block holds one pixel at a time; the next one is accepted the cycle after
// the result is captured.
// Reset clears the ring, the output valid flag and the configuration to c = 0,
// iteration_limit = 256.
module julia_escape_time (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [jet_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [jet_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // start_real [31:0], start_imag [63:32]
  input  logic [jet_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // iteration_count [15:0], reached_limit [16], final_mag_sq [50:17], zero fill above
  output logic [jet_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
  import jet_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t                   state;
  state_t                   state_next;
  logic signed [DATA_W-1:0] const_real;
  logic signed [DATA_W-1:0] const_imag;
  logic [LIMIT_W-1:0]       iteration_limit;
  jet_cfg_t                 cfg;

  cell_data_t               link [NUM_CELLS+1];
  cell_data_t               ring_in;
  cell_data_t               last;
  logic [NUM_CELLS-1:0]     ring_valid;
  logic                     accept;
  logic                     capture;

  logic                     out_valid;
  logic [OCNT_W-1:0]        out_count;
  logic                     out_reached;
  logic [MAG_W-1:0]         out_mag;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      const_real      <= '0;
      const_imag      <= '0;
      iteration_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CONST_REAL: const_real      <= cfg_data;
        CFG_CONST_IMAG: const_imag      <= cfg_data;
        CFG_ITER_LIMIT: iteration_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.const_real = const_real;
    cfg.const_imag = const_imag;
    cfg.limit_eff  = (32'(iteration_limit) > 32'(COUNT_MAX)) ? COUNT_MAX
                                                             : COUNT_BITS'(iteration_limit);
  end

  assign last          = link[NUM_CELLS];
  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign capture       = last.valid && last.done && (!out_valid || m_axis_tready);

  // A finished pixel keeps circling the ring until the output register is free.
  always_comb begin
    ring_in = last;
    if (capture) begin
      ring_in.valid = 1'b0;
    end
    if (accept) begin
      ring_in.valid   = 1'b1;
      ring_in.done    = 1'b0;
      ring_in.reached = 1'b0;
      ring_in.x       = s_axis_tdata[DATA_W-1:0];
      ring_in.y       = s_axis_tdata[2*DATA_W-1:DATA_W];
      ring_in.count   = '0;
      ring_in.mag     = '0;
    end
  end

  assign link[0] = ring_in;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    jet_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .cfg  (cfg),
      .din  (link[i]),
      .dout (link[i+1])
    );
    assign ring_valid[i] = link[i+1].valid;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_RUN;
      ST_RUN:  if (capture) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (capture) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (capture) begin
      out_count   <= OCNT_W'(last.count);
      out_reached <= last.reached;
      out_mag     <= last.mag;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_mag, out_reached, out_count};

  a_single_item: assert property (@(posedge clk) disable iff (rst)
    $countones(ring_valid) <= 1)
    else $error("more than one item in the ring");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (ring_valid == '0))
    else $error("ring holds an item while idle");

  a_capture_run: assert property (@(posedge clk) disable iff (rst)
    capture |=> (state == ST_IDLE) && out_valid)
    else $error("capture did not free the ring and fill the output");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    last.valid |-> (last.count <= cfg.limit_eff))
    else $error("iteration count ran past the limit");

endmodule
